@@ sv/crcma_pkg.sv @@
package crcma_pkg;

    // Reflected CRC-16/MODBUS polynomial and start value.
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Frame limit register width and reset value.
    localparam int unsigned LIMIT_W = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    // Width used for limit arithmetic; holds any frame limit up to 64.
    localparam int unsigned ROOM_W = 7;

    // Command queue between the front and the back.
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_AW    = 2;
    localparam int unsigned CMDQ_CW    = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_is_crc;
        logic       out_last;
        logic       truncated;
    } t_out_word;

    // One classified input byte, as handed from the front to the back.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        pass;
        logic        last;
        logic [15:0] crc;
        logic        trunc;
    } t_cmd;

    // One byte folded into the CRC, eight bit steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ sv/crcma_front.sv @@
module crcma_front
    import crcma_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_in_word           i_in_word,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    output t_cmd               o_cmd
);

    logic [LIMIT_W-1:0] r_frame_limit;
    logic [15:0]        r_crc;
    logic [5:0]         r_count;
    logic               r_dropped;

    logic [ROOM_W-1:0] w_max;
    logic [ROOM_W-1:0] w_limit;
    logic [ROOM_W-1:0] w_room;
    logic              w_pass;
    logic [15:0]       n_crc;
    logic              n_dropped;

    assign w_max   = ROOM_W'(MAX_FRAME);
    assign w_limit = ({1'b0, r_frame_limit} > w_max) ? w_max : {1'b0, r_frame_limit};
    assign w_room  = (w_limit > ROOM_W'(2)) ? (w_limit - ROOM_W'(2)) : '0;
    assign w_pass  = {1'b0, r_count} < w_room;

    assign n_crc     = w_pass ? crc_byte(r_crc, i_in_word.data_byte) : r_crc;
    assign n_dropped = r_dropped | ~w_pass;

    always_comb begin
        o_cmd.data_byte = i_in_word.data_byte;
        o_cmd.pass      = w_pass;
        o_cmd.last      = i_in_word.last_byte;
        o_cmd.crc       = n_crc;
        o_cmd.trunc     = n_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= LIMIT_RESET;
            r_crc         <= CRC_INIT;
            r_count       <= '0;
            r_dropped     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_limit <= i_cfg_data;
            end
            if (i_accept) begin
                if (i_in_word.last_byte) begin
                    r_crc     <= CRC_INIT;
                    r_count   <= '0;
                    r_dropped <= 1'b0;
                end else begin
                    r_crc     <= n_crc;
                    r_count   <= w_pass ? (r_count + 6'd1) : r_count;
                    r_dropped <= n_dropped;
                end
            end
        end
    end

endmodule

@@ sv/crcma_cmdq.sv @@
module crcma_cmdq
    import crcma_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_cmd,
    output logic o_full,
    input  logic i_rd,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr;
    logic [CMDQ_CW-1:0] r_count;

    logic w_wr;
    logic w_rd;

    assign o_full  = r_count == CMDQ_CW'(CMDQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign w_wr    = i_wr & ~o_full;
    assign w_rd    = i_rd & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + CMDQ_AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + CMDQ_AW'(1);
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + CMDQ_CW'(1);
                2'b01:   r_count <= r_count - CMDQ_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/crcma_back.sv @@
module crcma_back
    import crcma_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_word o_out_word
);

    typedef enum logic [1:0] {
        PH_PAY,
        PH_LO,
        PH_HI
    } t_phase;

    t_phase    r_phase;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic w_out_free;

    assign w_out_free = ~r_out_valid | i_pop;
    assign o_empty    = ~r_out_valid;
    assign o_out_word = r_out_word;

    // The command leaves the queue on the cycle its final word is loaded,
    // or at once when it gives no word at all.
    always_comb begin
        o_cmd_pop = 1'b0;
        if (i_cmd_valid && w_out_free) begin
            unique case (r_phase)
                PH_PAY:  o_cmd_pop = ~i_cmd.last;
                PH_LO:   o_cmd_pop = 1'b0;
                PH_HI:   o_cmd_pop = 1'b1;
                default: o_cmd_pop = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PAY;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd_valid && w_out_free) begin
                unique case (r_phase)
                    PH_PAY: begin
                        if (i_cmd.pass) begin
                            r_out_valid           <= 1'b1;
                            r_out_word.out_byte   <= i_cmd.data_byte;
                            r_out_word.out_is_crc <= 1'b0;
                            r_out_word.out_last   <= 1'b0;
                            r_out_word.truncated  <= i_cmd.trunc;
                            if (i_cmd.last) begin
                                r_phase <= PH_LO;
                            end
                        end else if (i_cmd.last) begin
                            r_out_valid           <= 1'b1;
                            r_out_word.out_byte   <= i_cmd.crc[7:0];
                            r_out_word.out_is_crc <= 1'b1;
                            r_out_word.out_last   <= 1'b0;
                            r_out_word.truncated  <= i_cmd.trunc;
                            r_phase               <= PH_HI;
                        end
                    end
                    PH_LO: begin
                        r_out_valid           <= 1'b1;
                        r_out_word.out_byte   <= i_cmd.crc[7:0];
                        r_out_word.out_is_crc <= 1'b1;
                        r_out_word.out_last   <= 1'b0;
                        r_out_word.truncated  <= i_cmd.trunc;
                        r_phase               <= PH_HI;
                    end
                    PH_HI: begin
                        r_out_valid           <= 1'b1;
                        r_out_word.out_byte   <= i_cmd.crc[15:8];
                        r_out_word.out_is_crc <= 1'b1;
                        r_out_word.out_last   <= 1'b1;
                        r_out_word.truncated  <= i_cmd.trunc;
                        r_phase               <= PH_PAY;
                    end
                    default: begin
                        r_phase <= PH_PAY;
                    end
                endcase
            end
        end
    end

endmodule

@@ sv/crc16_modbus_frame_appender.sv @@
// CRC-16/MODBUS frame appender.
// Input side is a queue: drive a payload word on i_in_word and raise push;
// the word is taken at a clock edge where push is high and full is low.
// last_byte marks the final payload byte of a frame.
// Output side is a queue too: while empty is low, o_out_word holds the
// oldest frame word; raise pop to take it. Payload bytes that fit within
// the frame limit pass through, then the CRC follows, low byte first,
// with out_last set on the high byte. Bytes beyond the limit are dropped
// and the CRC words then carry truncated.
// The frame limit is written through its own valid/ready channel, which
// is always ready; write it only while the block is idle.
// The block puts each accepted input word into the command queue and
// loads its first output word into the output register. It takes one input
// word per cycle while full is low and gives one output word per cycle
// while pop is high; a frame of N passed bytes gives N + 2 words. The
// single output register is the bottleneck at frame ends; a four-entry
// command queue absorbs the extra words. When the receiver stalls, the
// queue fills and full rises after at most five more input words.
// Reset clears the CRC to 0xFFFF, the byte count and drop flag to zero,
// the frame limit to 32, and empties both the queue and the output.
module crc16_modbus_frame_appender
    import crcma_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  t_in_word           i_in_word,
    output logic               empty,
    input  logic               pop,
    output t_out_word          o_out_word,
    input  logic               valid,
    output logic               ready,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    logic w_accept;
    logic w_cmd_full;
    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_front_cmd;
    t_cmd w_head_cmd;

    assign ready    = 1'b1;
    assign full     = w_cmd_full;
    assign w_accept = push & ~w_cmd_full;

    // Front: limit check, CRC update, frame state.
    crcma_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_in_word  (i_in_word),
        .i_cfg_we   (valid),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (w_front_cmd)
    );

    // Short queue of classified words between front and back.
    crcma_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (push),
        .i_wr_cmd (w_front_cmd),
        .o_full   (w_cmd_full),
        .i_rd     (w_cmd_pop),
        .o_valid  (w_cmd_valid),
        .o_head   (w_head_cmd)
    );

    // Back: expands each command into zero to three output words.
    crcma_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_head_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_word  (o_out_word)
    );

endmodule
